>>> sv/sfcs_pkg.sv
package sfcs_pkg;

  localparam logic [2:0] KIND_READ   = 3'd0;
  localparam logic [2:0] KIND_WRITE  = 3'd1;
  localparam logic [2:0] KIND_ERASE  = 3'd2;
  localparam logic [2:0] KIND_STATUS = 3'd3;
  localparam logic [2:0] KIND_FAIL   = 3'd4;

  localparam logic [2:0] ACT_WE   = 3'd0;
  localparam logic [2:0] ACT_RS   = 3'd1;
  localparam logic [2:0] ACT_CS   = 3'd2;
  localparam logic [2:0] ACT_RD   = 3'd3;
  localparam logic [2:0] ACT_PP   = 3'd4;
  localparam logic [2:0] ACT_SE   = 3'd5;
  localparam logic [2:0] ACT_DONE = 3'd6;
  localparam logic [2:0] ACT_FAIL = 3'd7;

  localparam logic [7:0] OP_READ  = 8'h03;
  localparam logic [7:0] OP_PROG  = 8'h02;
  localparam logic [7:0] OP_ERASE = 8'h20;
  localparam logic [7:0] OP_WREN  = 8'h06;
  localparam logic [7:0] OP_RDSR  = 8'h05;
  localparam logic [7:0] OP_WRSR  = 8'h01;
  localparam logic [7:0] OP_NONE  = 8'h00;

  localparam logic [7:0] ST_PROT_MASK = 8'hfc;
  localparam logic [7:0] ST_WEL_ONLY  = 8'h02;

  localparam logic [13:0] RDSR_LEN = 14'd1;
  localparam logic [13:0] WRSR_LEN = 14'd2;

  localparam int QDEPTH = 4;

  typedef enum logic [1:0] {
    MODE_IDLE  = 2'd0,
    MODE_READ  = 2'd1,
    MODE_WRITE = 2'd2,
    MODE_ERASE = 2'd3
  } mode_t;

  typedef enum logic [2:0] {
    PH_IDLE  = 3'd0,
    PH_WEN   = 3'd1,
    PH_POLL  = 3'd2,
    PH_FINAL = 3'd3
  } phase_t;

  typedef struct packed {
    logic [2:0]  kind;
    logic [23:0] start_address;
    logic [24:0] byte_count;
    logic [7:0]  status_byte;
  } in_item_t;

  typedef struct packed {
    logic [2:0]  action;
    logic [7:0]  opcode;
    logic [23:0] flash_address;
    logic [13:0] data_length;
    logic [24:0] buffer_offset;
    logic [24:0] result_count;
    logic        last_of_run;
  } out_item_t;

  // One run of results: optional head transaction, then optional WREN, then optional RDSR.
  typedef struct packed {
    logic      head_vld;
    logic      we;
    logic      rs;
    out_item_t head;
  } desc_t;

endpackage

>>> sv/sfcs_front.sv
module sfcs_front import sfcs_pkg::*; #(
  parameter int PAGE_BYTES   = 256,
  parameter int SECTOR_BYTES = 4096,
  parameter int READ_CHUNK   = 8192,
  parameter int ADDR_BITS    = 24
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_push,
  input  in_item_t in_data,
  input  logic     q_full,
  output logic     q_push,
  output desc_t    q_desc
);

  localparam int SEC_SH = $clog2(SECTOR_BYTES);
  localparam logic [24:0] SEC_MASK = 25'(SECTOR_BYTES - 1);
  localparam logic [24:0] ADDR_MASK = 25'((64'(1) << ADDR_BITS) - 64'(1));

  mode_t  mode_r, mode_nxt;
  phase_t phase_r, phase_nxt;
  logic [24:0] cur_addr_r, cur_addr_nxt;
  logic [24:0] rem_r, rem_nxt;
  logic [24:0] off_r, off_nxt;
  logic [13:0] chunk_r, chunk_nxt;
  logic [24:0] done_r, done_nxt;

  logic        accept, idle, is_req, is_stat, is_fail;
  logic [7:0]  st;
  logic        busy, wen_clr, wen_ok;
  logic [24:0] rd_len, wr_len, step_len, rem_after;
  logic        more;
  logic [24:0] req_addr, first_sec, end_addr, last_sec, sec_count;
  logic [13:0] page_room;
  logic [23:0] out_addr;

  assign accept  = in_push && !q_full;
  assign idle    = (mode_r == MODE_IDLE);
  assign is_req  = (in_data.kind == KIND_READ) || (in_data.kind == KIND_WRITE) ||
                   (in_data.kind == KIND_ERASE);
  assign is_stat = (in_data.kind == KIND_STATUS);
  assign is_fail = (in_data.kind == KIND_FAIL);
  assign st      = in_data.status_byte;
  assign busy    = st[0];
  assign wen_clr = ((st & ST_PROT_MASK) != 8'h00) && st[1];
  assign wen_ok  = (st == ST_WEL_ONLY);

  // piece arithmetic for a data step
  always_comb begin
    rd_len   = (rem_r < 25'(READ_CHUNK)) ? rem_r : 25'(READ_CHUNK);
    wr_len   = ({11'd0, chunk_r} < rem_r) ? {11'd0, chunk_r} : rem_r;
    step_len = (mode_r == MODE_READ) ? rd_len : wr_len;
    if (mode_r == MODE_ERASE) begin
      rem_after = (rem_r != 25'd0) ? rem_r - 25'd1 : rem_r;
    end else begin
      rem_after = rem_r - step_len;
    end
    more     = (rem_after != 25'd0);
    out_addr = 24'(cur_addr_r & ADDR_MASK);
  end

  // request setup arithmetic
  always_comb begin
    req_addr  = {1'b0, in_data.start_address};
    first_sec = req_addr & ~SEC_MASK;
    end_addr  = (in_data.byte_count != 25'd0) ? req_addr + in_data.byte_count - 25'd1
                                               : req_addr;
    last_sec  = end_addr & ~SEC_MASK;
    sec_count = ((last_sec - first_sec) >> SEC_SH) + 25'd1;
    page_room = 14'(PAGE_BYTES) -
                14'(in_data.start_address & 24'(PAGE_BYTES - 1));
  end

  // next state
  always_comb begin
    mode_nxt  = mode_r;
    phase_nxt = phase_r;
    if (accept) begin
      if (is_req && idle) begin
        unique case (in_data.kind)
          KIND_READ: begin
            mode_nxt  = MODE_READ;
            phase_nxt = PH_POLL;
          end
          KIND_WRITE: begin
            mode_nxt  = MODE_WRITE;
            phase_nxt = PH_WEN;
          end
          default: begin
            mode_nxt  = MODE_ERASE;
            phase_nxt = PH_WEN;
          end
        endcase
      end else if (is_stat && !idle) begin
        unique case (phase_r)
          PH_WEN: begin
            if (!wen_clr && wen_ok) phase_nxt = PH_POLL;
          end
          PH_POLL: begin
            if (!busy) begin
              if (more && mode_r != MODE_READ) phase_nxt = PH_WEN;
              else if (more)                   phase_nxt = PH_POLL;
              else                             phase_nxt = PH_FINAL;
            end
          end
          default: begin
            if (!busy) begin
              mode_nxt  = MODE_IDLE;
              phase_nxt = PH_IDLE;
            end
          end
        endcase
      end else if (is_fail && !idle) begin
        mode_nxt  = MODE_IDLE;
        phase_nxt = PH_IDLE;
      end
    end
  end

  // outputs and datapath
  always_comb begin
    cur_addr_nxt = cur_addr_r;
    rem_nxt      = rem_r;
    off_nxt      = off_r;
    chunk_nxt    = chunk_r;
    done_nxt     = done_r;
    q_push       = 1'b0;
    q_desc       = '0;
    if (accept) begin
      if (is_req && idle) begin
        q_push       = 1'b1;
        q_desc.rs    = 1'b1;
        q_desc.we    = (in_data.kind != KIND_READ);
        cur_addr_nxt = req_addr;
        rem_nxt      = in_data.byte_count;
        off_nxt      = 25'd0;
        done_nxt     = 25'd0;
        if (in_data.kind == KIND_WRITE) chunk_nxt = page_room;
        if (in_data.kind == KIND_ERASE) begin
          cur_addr_nxt = first_sec;
          rem_nxt      = sec_count;
        end
      end else if (is_stat && !idle) begin
        q_push = 1'b1;
        unique case (phase_r)
          PH_WEN: begin
            q_desc.rs = 1'b1;
            if (wen_clr) begin
              q_desc.head_vld         = 1'b1;
              q_desc.head.action      = ACT_CS;
              q_desc.head.opcode      = OP_WRSR;
              q_desc.head.data_length = WRSR_LEN;
              q_desc.we               = 1'b1;
            end else if (!wen_ok) begin
              q_desc.we = 1'b1;
            end
          end
          PH_POLL: begin
            q_desc.rs = 1'b1;
            if (!busy) begin
              q_desc.head_vld           = 1'b1;
              q_desc.head.flash_address = out_addr;
              q_desc.we                 = more && (mode_r != MODE_READ);
              rem_nxt                   = rem_after;
              if (mode_r == MODE_ERASE) begin
                q_desc.head.action = ACT_SE;
                q_desc.head.opcode = OP_ERASE;
                cur_addr_nxt       = cur_addr_r + 25'(SECTOR_BYTES);
                done_nxt           = done_r + 25'd1;
              end else begin
                q_desc.head.action        = (mode_r == MODE_READ) ? ACT_RD : ACT_PP;
                q_desc.head.opcode        = (mode_r == MODE_READ) ? OP_READ : OP_PROG;
                q_desc.head.data_length   = 14'(step_len);
                q_desc.head.buffer_offset = off_r;
                cur_addr_nxt              = cur_addr_r + step_len;
                off_nxt                   = off_r + step_len;
                done_nxt                  = done_r + step_len;
                if (mode_r == MODE_WRITE) chunk_nxt = 14'(PAGE_BYTES);
              end
            end
          end
          default: begin
            if (busy) begin
              q_desc.rs = 1'b1;
            end else begin
              q_desc.head_vld          = 1'b1;
              q_desc.head.action       = ACT_DONE;
              q_desc.head.opcode       = OP_NONE;
              q_desc.head.result_count = done_r;
            end
          end
        endcase
      end else if (is_fail && !idle) begin
        q_push             = 1'b1;
        q_desc.head_vld    = 1'b1;
        q_desc.head.action = ACT_FAIL;
        q_desc.head.opcode = OP_NONE;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r     <= MODE_IDLE;
      phase_r    <= PH_IDLE;
      cur_addr_r <= '0;
      rem_r      <= '0;
      off_r      <= '0;
      chunk_r    <= '0;
      done_r     <= '0;
    end else begin
      mode_r     <= mode_nxt;
      phase_r    <= phase_nxt;
      cur_addr_r <= cur_addr_nxt;
      rem_r      <= rem_nxt;
      off_r      <= off_nxt;
      chunk_r    <= chunk_nxt;
      done_r     <= done_nxt;
    end
  end

  a_mode_phase_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (mode_r == MODE_IDLE) == (phase_r == PH_IDLE))
    else $error("mode and phase disagree on idle");

  a_req_starts: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && is_req && idle) |=> (mode_r != MODE_IDLE))
    else $error("accepted request did not start an operation");

endmodule

>>> sv/sfcs_queue.sv
module sfcs_queue import sfcs_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  push,
  input  desc_t push_desc,
  input  logic  pop,
  output logic  full,
  output logic  nempty,
  output desc_t head_desc
);

  localparam int PW = $clog2(QDEPTH);

  desc_t            mem_r [QDEPTH];
  logic [PW-1:0]    wr_ptr_r, rd_ptr_r;
  logic [PW:0]      count_r;
  logic             do_push, do_pop;

  assign full      = (count_r == (PW+1)'(QDEPTH));
  assign nempty    = (count_r != '0);
  assign head_desc = mem_r[rd_ptr_r];
  assign do_push   = push && !full;
  assign do_pop    = pop && nempty;

  always_ff @(posedge clk) begin
    if (do_push) mem_r[wr_ptr_r] <= push_desc;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) wr_ptr_r <= wr_ptr_r + PW'(1);
      if (do_pop)  rd_ptr_r <= rd_ptr_r + PW'(1);
      if (do_push && !do_pop)      count_r <= count_r + (PW+1)'(1);
      else if (do_pop && !do_push) count_r <= count_r - (PW+1)'(1);
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= (PW+1)'(QDEPTH))
    else $error("queue count overflow");

endmodule

>>> sv/sfcs_back.sv
module sfcs_back import sfcs_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      q_nempty,
  input  desc_t     q_head,
  output logic      q_pop,
  input  logic      out_pop,
  output logic      out_empty,
  output out_item_t out_data
);

  // bit 0 head transaction, bit 1 write enable, bit 2 status read
  logic [2:0] flags, rem, sel, em_r, em_nxt;
  logic       last, adv;
  logic       out_vld_r, out_vld_nxt;
  out_item_t  out_data_r, out_data_nxt, res;

  assign flags = {q_head.rs, q_head.we, q_head.head_vld};
  assign rem   = flags & ~em_r;
  assign adv   = q_nempty && (!out_vld_r || out_pop);

  always_comb begin
    priority if (rem[0]) sel = 3'b001;
    else if (rem[1])     sel = 3'b010;
    else                 sel = 3'b100;
    last = ((rem & ~sel) == 3'b000);
  end

  always_comb begin
    res = '0;
    unique case (sel)
      3'b001: res = q_head.head;
      3'b010: begin
        res.action = ACT_WE;
        res.opcode = OP_WREN;
      end
      default: begin
        res.action      = ACT_RS;
        res.opcode      = OP_RDSR;
        res.data_length = RDSR_LEN;
      end
    endcase
    res.last_of_run = last;
  end

  always_comb begin
    em_nxt       = em_r;
    out_vld_nxt  = out_vld_r;
    out_data_nxt = out_data_r;
    q_pop        = 1'b0;
    if (adv) begin
      out_vld_nxt  = 1'b1;
      out_data_nxt = res;
      if (last) begin
        q_pop  = 1'b1;
        em_nxt = 3'b000;
      end else begin
        em_nxt = em_r | sel;
      end
    end else if (out_pop) begin
      out_vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
    if (!rst_n) begin
      em_r      <= '0;
      out_vld_r <= 1'b0;
    end else begin
      em_r      <= em_nxt;
      out_vld_r <= out_vld_nxt;
    end
  end

  assign out_empty = !out_vld_r;
  assign out_data  = out_data_r;

  a_em_subset: assert property (@(posedge clk) disable iff (!rst_n)
    (q_nempty && em_r != 3'b000) |-> ((em_r & ~flags) == 3'b000))
    else $error("emitted mask outside descriptor");

endmodule

>>> sv/spi_flash_command_sequencer.sv
// A result item passes through the run queue and then the output register to the out_ ports.
// Throughput: one result per cycle unless out_pop stalls; the n results (1 to 3) of an input
// leave via the single output register; the front takes one input per cycle unless in_full.
// A four-entry run queue between the front and the result expander absorbs bursts.
// Reset: synchronous on rst_n low; clears the operation state, queue and output valid.
module spi_flash_command_sequencer import sfcs_pkg::*; #(
  parameter int PAGE_BYTES   = 256,
  parameter int SECTOR_BYTES = 4096,
  parameter int READ_CHUNK   = 8192,
  parameter int ADDR_BITS    = 24
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_push,
  output logic      in_full,
  input  in_item_t  in_data,
  input  logic      out_pop,
  output logic      out_empty,
  output out_item_t out_data
);

  logic  q_push, q_full, q_nempty, q_pop;
  desc_t q_desc, q_head;

  assign in_full = q_full;

  sfcs_front #(
    .PAGE_BYTES  (PAGE_BYTES),
    .SECTOR_BYTES(SECTOR_BYTES),
    .READ_CHUNK  (READ_CHUNK),
    .ADDR_BITS   (ADDR_BITS)
  ) u_front (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_push(in_push),
    .in_data(in_data),
    .q_full (q_full),
    .q_push (q_push),
    .q_desc (q_desc)
  );

  sfcs_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_desc(q_desc),
    .pop      (q_pop),
    .full     (q_full),
    .nempty   (q_nempty),
    .head_desc(q_head)
  );

  sfcs_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .q_nempty (q_nempty),
    .q_head   (q_head),
    .q_pop    (q_pop),
    .out_pop  (out_pop),
    .out_empty(out_empty),
    .out_data (out_data)
  );

endmodule

>>> dv/tb_top.sv
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import sfcs_pkg::*;

  localparam int PAGE_BYTES   = 256;
  localparam int SECTOR_BYTES = 4096;
  localparam int READ_CHUNK   = 8192;

  localparam logic [7:0] ST_BUSY      = 8'h01;
  localparam logic [2:0] KIND_RSVD_LO = 3'd5;
  localparam logic [2:0] KIND_RSVD_HI = 3'd7;

  localparam int STALL_LIMIT = 2000;
  localparam int RECV_HOLD   = 300;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_push = 1'b0;
  logic      in_full;
  in_item_t  in_data = '0;
  logic      out_pop = 1'b0;
  logic      out_empty;
  out_item_t out_data;

  // predictor state
  mode_t       seq_mode = MODE_IDLE;
  phase_t      seq_phase = PH_IDLE;
  logic [24:0] seq_addr = '0;
  logic [24:0] seq_left = '0;
  logic [24:0] seq_offset = '0;
  logic [24:0] seq_tally = '0;
  logic [13:0] page_room = '0;

  out_item_t pending_txns[$];

  int error_count = 0;
  int live_items = 0;
  bit idling_on = 1'b1;
  int hold_request = 0;
  int hold_left = 0;
  int stall_cycles = 0;

  always #4ns clk = ~clk;

  spi_flash_command_sequencer DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_push   (in_push),
    .in_full   (in_full),
    .in_data   (in_data),
    .out_pop   (out_pop),
    .out_empty (out_empty),
    .out_data  (out_data)
  );

  task automatic report_error(string msg);
    error_count++;
    if (error_count <= 40) $display("[%0t] ERROR: %s", $time, msg);
  endtask

  function automatic void expect_txn(logic [2:0] act, logic [7:0] op, logic [24:0] addr,
                                     logic [13:0] len, logic [24:0] off, logic [24:0] cnt);
    out_item_t t;
    t.action        = act;
    t.opcode        = op;
    t.flash_address = addr[23:0];
    t.data_length   = len;
    t.buffer_offset = off;
    t.result_count  = cnt;
    t.last_of_run   = 1'b0;
    pending_txns.push_back(t);
  endfunction

  function automatic void expect_poll();
    expect_txn(ACT_RS, OP_RDSR, '0, RDSR_LEN, '0, '0);
  endfunction

  function automatic void expect_wren();
    expect_txn(ACT_WE, OP_WREN, '0, '0, '0, '0);
  endfunction

  // Busy-clear poll in the data phase: issue the next piece and move on.
  function automatic void issue_piece();
    logic [31:0] len;
    case (seq_mode)
      MODE_READ: begin
        len = (seq_left < READ_CHUNK) ? 32'(seq_left) : READ_CHUNK;
        expect_txn(ACT_RD, OP_READ, seq_addr, len[13:0], seq_offset, '0);
      end
      MODE_WRITE: begin
        len = (page_room < seq_left) ? 32'(page_room) : 32'(seq_left);
        expect_txn(ACT_PP, OP_PROG, seq_addr, len[13:0], seq_offset, '0);
        page_room = 14'(PAGE_BYTES);
      end
      default: begin
        len = 0;
        expect_txn(ACT_SE, OP_ERASE, seq_addr, '0, '0, '0);
        seq_addr  = seq_addr + 25'(SECTOR_BYTES);
        seq_tally = seq_tally + 25'd1;
        if (seq_left != 0) seq_left = seq_left - 25'd1;
      end
    endcase
    if (seq_mode != MODE_ERASE) begin
      seq_addr   = seq_addr + len[24:0];
      seq_offset = seq_offset + len[24:0];
      seq_tally  = seq_tally + len[24:0];
      seq_left   = seq_left - len[24:0];
    end
    if (seq_left != 0 && seq_mode != MODE_READ) begin
      seq_phase = PH_WEN;
      expect_wren();
      expect_poll();
    end else begin
      seq_phase = (seq_left != 0) ? PH_POLL : PH_FINAL;
      expect_poll();
    end
  endfunction

  function automatic void take_status(logic [7:0] st);
    case (seq_phase)
      PH_WEN: begin
        if ((st & ST_PROT_MASK) != 0 && (st & ST_WEL_ONLY) != 0) begin
          expect_txn(ACT_CS, OP_WRSR, '0, WRSR_LEN, '0, '0);
          expect_wren();
          expect_poll();
        end else if (st != ST_WEL_ONLY) begin
          expect_wren();
          expect_poll();
        end else begin
          seq_phase = PH_POLL;
          expect_poll();
        end
      end
      PH_POLL: begin
        if ((st & ST_BUSY) != 0) expect_poll();
        else issue_piece();
      end
      default: begin
        if ((st & ST_BUSY) != 0) begin
          expect_poll();
        end else begin
          expect_txn(ACT_DONE, OP_NONE, '0, '0, '0, seq_tally);
          seq_mode  = MODE_IDLE;
          seq_phase = PH_IDLE;
        end
      end
    endcase
  endfunction

  // Returns the number of transactions the accepted item should produce.
  function automatic int sequence_txns(in_item_t it);
    int n0;
    logic [31:0] first, last_byte, last;
    out_item_t t;
    n0 = pending_txns.size();
    case (it.kind)
      KIND_READ, KIND_WRITE, KIND_ERASE: begin
        if (seq_mode == MODE_IDLE) begin
          seq_addr   = {1'b0, it.start_address};
          seq_left   = it.byte_count;
          seq_offset = '0;
          seq_tally  = '0;
          if (it.kind == KIND_READ) begin
            seq_mode  = MODE_READ;
            seq_phase = PH_POLL;
            expect_poll();
          end else begin
            if (it.kind == KIND_WRITE) begin
              seq_mode  = MODE_WRITE;
              page_room = 14'(PAGE_BYTES - (32'(it.start_address) & (PAGE_BYTES - 1)));
            end else begin
              seq_mode  = MODE_ERASE;
              first     = 32'(it.start_address) & ~32'(SECTOR_BYTES - 1);
              last_byte = (it.byte_count != 0) ?
                          32'(it.start_address) + 32'(it.byte_count) - 1 :
                          32'(it.start_address);
              last      = last_byte & ~32'(SECTOR_BYTES - 1);
              seq_addr  = first[24:0];
              seq_left  = 25'((last - first) / SECTOR_BYTES + 1);
            end
            seq_phase = PH_WEN;
            expect_wren();
            expect_poll();
          end
        end
      end
      KIND_STATUS: begin
        if (seq_mode != MODE_IDLE) take_status(it.status_byte);
      end
      KIND_FAIL: begin
        if (seq_mode != MODE_IDLE) begin
          expect_txn(ACT_FAIL, OP_NONE, '0, '0, '0, '0);
          seq_mode  = MODE_IDLE;
          seq_phase = PH_IDLE;
        end
      end
      default: ;
    endcase
    if (pending_txns.size() > n0) begin
      t = pending_txns.pop_back();
      t.last_of_run = 1'b1;
      pending_txns.push_back(t);
    end
    return pending_txns.size() - n0;
  endfunction

  function automatic in_item_t make_item(logic [2:0] kind, logic [23:0] addr,
                                         logic [24:0] cnt, logic [7:0] st);
    in_item_t it;
    it.kind          = kind;
    it.start_address = addr;
    it.byte_count    = cnt;
    it.status_byte   = st;
    return it;
  endfunction

  task automatic send_item(in_item_t it);
    if (idling_on && $urandom_range(99) < 30) begin
      in_push <= 1'b0;
      repeat ($urandom_range(1, 2)) @(posedge clk);
    end
    in_push <= 1'b1;
    in_data <= it;
    @(posedge clk);
    while (in_full) @(posedge clk);
    if (sequence_txns(it) != 0) live_items++;
  endtask

  task automatic send_status(logic [7:0] st);
    send_item(make_item(KIND_STATUS, 24'($urandom), 25'($urandom), st));
  endtask

  // Stop offering and wait for every outstanding transfer on the result side.
  task automatic drain();
    in_push <= 1'b0;
    @(posedge clk);
    while (pending_txns.size() != 0) @(posedge clk);
  endtask

  // Feed replies (mostly sensible for the current phase) until the request ends.
  task automatic answer_request(int max_replies);
    int replies;
    logic [7:0] st;
    replies = 0;
    while (seq_mode != MODE_IDLE) begin
      if (replies >= max_replies || $urandom_range(99) < 2) begin
        send_item(make_item(KIND_FAIL, 24'($urandom), 25'($urandom), 8'($urandom)));
      end else if ($urandom_range(99) < 5) begin
        if ($urandom_range(1) == 0)
          send_item(make_item(3'($urandom_range(KIND_READ, KIND_ERASE)), 24'($urandom),
                              25'($urandom), 8'($urandom)));
        else
          send_item(make_item(3'($urandom_range(KIND_RSVD_LO, KIND_RSVD_HI)), 24'($urandom),
                              25'($urandom), 8'($urandom)));
      end else begin
        st = 8'($urandom);
        if (seq_phase == PH_WEN) begin
          if ($urandom_range(99) < 70) st = ST_WEL_ONLY;
        end else if ($urandom_range(99) < 75) begin
          st = st & ~ST_BUSY;
        end else begin
          st = st | ST_BUSY;
        end
        send_status(st);
        replies++;
      end
    end
  endtask

  task automatic random_request();
    logic [2:0]  kind;
    logic [23:0] addr;
    logic [24:0] cnt;
    int          r;
    int          max_replies;
    if ($urandom_range(99) < 10)
      send_item(make_item($urandom_range(1) ? KIND_STATUS : KIND_FAIL, 24'($urandom),
                          25'($urandom), 8'($urandom)));
    kind = 3'($urandom_range(KIND_READ, KIND_ERASE));
    addr = 24'($urandom);
    if ($urandom_range(3) == 0) addr[11:0] = 12'hfff - 12'($urandom_range(0, 15));
    r = $urandom_range(99);
    max_replies = 60;
    if (r < 8) begin
      cnt = 25'($urandom_range(0, 16777216));
      max_replies = 12;
    end else if (r < 15) begin
      cnt = '0;
    end else begin
      case (kind)
        KIND_READ:  cnt = 25'($urandom_range(1, 20000));
        KIND_WRITE: cnt = 25'($urandom_range(1, 700));
        default:    cnt = 25'($urandom_range(1, 10000));
      endcase
    end
    send_item(make_item(kind, addr, cnt, 8'($urandom)));
    answer_request(max_replies);
  endtask

  task automatic test_read_paths();
    send_item(make_item(KIND_READ, 24'h000000, 25'd0, 8'h00));   // zero-length read
    send_status(8'h00);
    send_status(8'h00);
    send_item(make_item(KIND_READ, 24'hffffff, 25'd8193, 8'hff)); // two chunks, address wraps
    send_status(ST_BUSY);
    send_status(8'h00);
    send_status(8'h00);
    send_status(8'h00);
    drain();
  endtask

  task automatic test_write_paths();
    send_item(make_item(KIND_WRITE, 24'hffff80, 25'd300, 8'h00));
    send_status(8'hfe);          // protection bits with WEL: clear then retry
    send_status(8'h03);          // anything but WEL alone: retry
    send_status(ST_WEL_ONLY);
    send_status(8'h00);          // first piece up to the page end
    send_status(ST_WEL_ONLY);
    send_status(8'h00);
    send_status(8'h00);
    drain();
  endtask

  task automatic test_erase_paths();
    send_item(make_item(KIND_ERASE, 24'habcdef, 25'd0, 8'h00));  // zero-length erase
    send_status(ST_WEL_ONLY);
    send_status(8'h00);
    send_status(8'h00);
    // end lands on a sector boundary: only one sector
    send_item(make_item(KIND_ERASE, 24'h001000, 25'd4096, 8'h00));
    send_status(ST_WEL_ONLY);
    send_status(8'h00);
    send_status(8'h00);
    drain();
  endtask

  task automatic test_ignored_and_abort();
    send_status(8'h55);
    send_item(make_item(KIND_FAIL, 24'h5a5a5a, 25'h0a5a5a5, 8'haa));
    send_item(make_item(KIND_RSVD_HI, 24'hffffff, 25'h1ffffff, 8'hff));
    send_item(make_item(KIND_ERASE, 24'hffffff, 25'h1000000, 8'h00));
    send_item(make_item(KIND_WRITE, 24'h000100, 25'd16, 8'h00));  // busy: dropped
    send_status(ST_WEL_ONLY);
    send_status(8'h00);
    send_item(make_item(KIND_FAIL, 24'h000000, 25'd0, 8'h00));
    drain();
  endtask

  // Receiver holds off while the sender keeps going, so the input side stalls.
  task automatic test_backpressure();
    hold_request = RECV_HOLD;
    send_item(make_item(KIND_WRITE, {12'($urandom), 12'h000}, 25'd3000, 8'h00));
    answer_request(20);
    drain();
  endtask

  task automatic test_random_traffic(int target, bit with_idle);
    int start;
    idling_on = with_idle;
    start = live_items;
    while (live_items - start < target) random_request();
    drain();
    idling_on = 1'b1;
  endtask

  always @(posedge clk) begin
    if (hold_request != 0) begin
      hold_left = hold_request;
      hold_request = 0;
    end
    if (hold_left != 0) begin
      hold_left--;
      out_pop <= 1'b0;
    end else begin
      out_pop <= !idling_on || ($urandom_range(99) >= 30);
    end
  end

  always @(posedge clk) begin : check_results
    out_item_t want;
    if (rst_n && out_pop && !out_empty) begin
      if (pending_txns.size() == 0) begin
        report_error($sformatf("transfer with nothing expected: action %0d", out_data.action));
      end else begin
        want = pending_txns.pop_front();
        if (out_data.action !== want.action)
          report_error($sformatf("action %0d, expected %0d", out_data.action, want.action));
        if (out_data.opcode !== want.opcode)
          report_error($sformatf("opcode %0h, expected %0h", out_data.opcode, want.opcode));
        if (out_data.flash_address !== want.flash_address)
          report_error($sformatf("flash_address %0h, expected %0h",
                                 out_data.flash_address, want.flash_address));
        if (out_data.data_length !== want.data_length)
          report_error($sformatf("data_length %0d, expected %0d",
                                 out_data.data_length, want.data_length));
        if (out_data.buffer_offset !== want.buffer_offset)
          report_error($sformatf("buffer_offset %0d, expected %0d",
                                 out_data.buffer_offset, want.buffer_offset));
        if (out_data.result_count !== want.result_count)
          report_error($sformatf("result_count %0d, expected %0d",
                                 out_data.result_count, want.result_count));
        if (out_data.last_of_run !== want.last_of_run)
          report_error($sformatf("last_of_run %0b, expected %0b",
                                 out_data.last_of_run, want.last_of_run));
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_push && !in_full) || (out_pop && !out_empty)) stall_cycles = 0;
    else stall_cycles++;
    if (stall_cycles >= STALL_LIMIT) begin
      report_error($sformatf("no transfer for %0d cycles, %0d results outstanding",
                             STALL_LIMIT, pending_txns.size()));
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  initial begin
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    test_read_paths();
    test_write_paths();
    test_erase_paths();
    test_ignored_and_abort();
    test_random_traffic(85, 1'b1);
    test_backpressure();
    test_random_traffic(30, 1'b0);
    repeat (8) @(posedge clk);
    if (pending_txns.size() != 0)
      report_error($sformatf("%0d results never arrived", pending_txns.size()));
    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

>>> files.f
sv/sfcs_pkg.sv
sv/sfcs_front.sv
sv/sfcs_queue.sv
sv/sfcs_back.sv
sv/spi_flash_command_sequencer.sv
dv/tb_top.sv
